FILE: design/abkf_pkg.sv
// ----------------------------------------------------------------------------
// abkf_pkg
// Shared types and codes for the angle/bias Kalman filter.
// ----------------------------------------------------------------------------
package abkf_pkg;

  localparam int unsigned CFG_IDX_W = 2;

  localparam logic [CFG_IDX_W-1:0] CFG_ANGLE_NOISE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_BIAS_NOISE  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_MEAS_NOISE  = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_START_ANGLE = 2'd3;

  typedef enum logic [4:0] {
    OP_RATE      = 5'd0,
    OP_ANG_PRED  = 5'd1,
    OP_CBD       = 5'd2,
    OP_T1        = 5'd3,
    OP_T2        = 5'd4,
    OP_T3        = 5'd5,
    OP_P00_PRED  = 5'd6,
    OP_P01_PRED  = 5'd7,
    OP_P10_PRED  = 5'd8,
    OP_P11_PRED  = 5'd9,
    OP_INNOV     = 5'd10,
    OP_GAIN      = 5'd11,
    OP_RESID     = 5'd12,
    OP_ANG_CORR  = 5'd13,
    OP_BIAS_CORR = 5'd14,
    OP_P10_CORR  = 5'd15,
    OP_P00_CORR  = 5'd16,
    OP_P11_CORR  = 5'd17,
    OP_P01_CORR  = 5'd18
  } abkf_op_e;

  localparam abkf_op_e OP_FIRST = OP_RATE;
  localparam abkf_op_e OP_LAST  = OP_P01_CORR;

  typedef struct packed {
    logic     load;
    logic     issue;
    abkf_op_e op;
    logic     capture;
  } abkf_cmd_t;

  typedef struct packed {
    logic done;
  } abkf_sts_t;

endpackage

FILE: design/abkf_div.sv
// ----------------------------------------------------------------------------
// abkf_div
// Two-lane restoring fixed-point divider sharing one divisor, one bit a cycle.
// ----------------------------------------------------------------------------
module abkf_div #(
  parameter int unsigned DW = 32,
  parameter int unsigned FB = 16
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 start_i,
  input  logic signed [DW-1:0] num0_i,
  input  logic signed [DW-1:0] num1_i,
  input  logic signed [DW-1:0] den_i,
  output logic                 done_o,
  output logic signed [DW-1:0] quo0_o,
  output logic signed [DW-1:0] quo1_o
);

  localparam int unsigned N  = DW + FB;
  localparam int unsigned CW = $clog2(N + 1);
  localparam logic [N-1:0] LIM_P = {{(N-DW+1){1'b0}}, {(DW-1){1'b1}}};
  localparam logic [N-1:0] LIM_N = LIM_P + N'(1);

  function automatic logic [DW-1:0] mag(input logic signed [DW-1:0] x);
    logic [DW-1:0] r;
    r = x[DW-1] ? DW'(-x) : DW'(x);
    return r;
  endfunction

  logic                 busy_q, busy_d;
  logic                 done_q, done_d;
  logic [CW-1:0]        cnt_q, cnt_d;
  logic [DW-1:0]        den_q, den_d;
  logic [1:0]           neg_q, neg_d;
  logic [N-1:0]         sh_q [2];
  logic [N-1:0]         sh_d [2];
  logic [DW-1:0]        rem_q [2];
  logic [DW-1:0]        rem_d [2];
  logic [N-1:0]         quo_q [2];
  logic [N-1:0]         quo_d [2];
  logic signed [DW-1:0] res_q [2];
  logic signed [DW-1:0] res_d [2];

  always_comb begin
    logic [DW:0]   rs;
    logic          ge;
    logic [N-1:0]  lim;
    logic [N-1:0]  qc;
    rs     = '0;
    ge     = 1'b0;
    lim    = '0;
    qc     = '0;
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    den_d  = den_q;
    neg_d  = neg_q;
    for (int l = 0; l < 2; l++) begin
      sh_d[l]  = sh_q[l];
      rem_d[l] = rem_q[l];
      quo_d[l] = quo_q[l];
      res_d[l] = res_q[l];
    end
    if (start_i) begin
      busy_d   = 1'b1;
      cnt_d    = '0;
      den_d    = mag(den_i);
      neg_d[0] = num0_i[DW-1] ^ den_i[DW-1];
      neg_d[1] = num1_i[DW-1] ^ den_i[DW-1];
      sh_d[0]  = {mag(num0_i), {FB{1'b0}}};
      sh_d[1]  = {mag(num1_i), {FB{1'b0}}};
      for (int l = 0; l < 2; l++) begin
        rem_d[l] = '0;
        quo_d[l] = '0;
      end
    end else if (busy_q) begin
      for (int l = 0; l < 2; l++) begin
        rs       = {rem_q[l], sh_q[l][N-1]};
        ge       = rs >= {1'b0, den_q};
        rem_d[l] = ge ? DW'(rs - {1'b0, den_q}) : rs[DW-1:0];
        quo_d[l] = {quo_q[l][N-2:0], ge};
        sh_d[l]  = sh_q[l] << 1;
        lim      = neg_q[l] ? LIM_N : LIM_P;
        qc       = (quo_d[l] > lim) ? lim : quo_d[l];
        if (cnt_q == CW'(N - 1)) begin
          res_d[l] = neg_q[l] ? -$signed(qc[DW-1:0]) : $signed(qc[DW-1:0]);
        end
      end
      if (cnt_q == CW'(N - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end else begin
        cnt_d = cnt_q + CW'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    den_q <= den_d;
    neg_q <= neg_d;
    for (int l = 0; l < 2; l++) begin
      sh_q[l]  <= sh_d[l];
      rem_q[l] <= rem_d[l];
      quo_q[l] <= quo_d[l];
      res_q[l] <= res_d[l];
    end
  end

  assign done_o = done_q;
  assign quo0_o = res_q[0];
  assign quo1_o = res_q[1];

endmodule

FILE: design/abkf_dp.sv
// ----------------------------------------------------------------------------
// abkf_dp
// Filter datapath: state, configuration, shared multiplier and divider.
// ----------------------------------------------------------------------------
module abkf_dp #(
  parameter int unsigned DW = 32,
  parameter int unsigned FB = 16
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  abkf_pkg::abkf_cmd_t              cmd_i,
  output abkf_pkg::abkf_sts_t              sts_o,
  input  logic                             cfg_we_i,
  input  logic [abkf_pkg::CFG_IDX_W-1:0]   cfg_index_i,
  input  logic [31:0]                      cfg_data_i,
  input  logic signed [31:0]               measured_angle_i,
  input  logic signed [31:0]               gyro_rate_i,
  input  logic [15:0]                      time_step_i,
  output logic signed [31:0]               angle_estimate_o,
  output logic signed [31:0]               bias_estimate_o
);

  localparam int unsigned XW  = ((DW > 32) ? DW : 32) + 2;
  localparam int unsigned NCH = (DW + 15) / 16;
  localparam int unsigned BW  = NCH * 16;
  localparam int unsigned PW  = DW + BW;
  localparam int unsigned MCW = (NCH > 1) ? $clog2(NCH) : 1;

  localparam logic signed [XW-1:0] MAXV_X = XW'((64'sd1 <<< (DW - 1)) - 64'sd1);
  localparam logic signed [XW-1:0] MINV_X = XW'(-(64'sd1 <<< (DW - 1)));
  localparam logic signed [XW-1:0] OMAX_X = XW'(64'sd2147483647);
  localparam logic signed [XW-1:0] OMIN_X = XW'(-64'sd2147483648);
  localparam logic signed [DW-1:0] ONE =
    (FB >= DW - 1) ? {1'b0, {(DW-1){1'b1}}} : DW'(64'sd1 <<< FB);
  localparam logic [PW-1:0] LIM_P = {{(PW-DW+1){1'b0}}, {(DW-1){1'b1}}};
  localparam logic [PW-1:0] LIM_N = LIM_P + PW'(1);

  function automatic logic signed [DW-1:0] sat_x(input logic signed [XW-1:0] x);
    logic signed [DW-1:0] r;
    if (x > MAXV_X) r = MAXV_X[DW-1:0];
    else if (x < MINV_X) r = MINV_X[DW-1:0];
    else r = x[DW-1:0];
    return r;
  endfunction

  function automatic logic signed [DW-1:0] add_s(input logic signed [DW-1:0] a,
                                                 input logic signed [DW-1:0] b);
    logic signed [DW-1:0] r;
    r = sat_x(XW'(a) + XW'(b));
    return r;
  endfunction

  function automatic logic signed [DW-1:0] sub_s(input logic signed [DW-1:0] a,
                                                 input logic signed [DW-1:0] b);
    logic signed [DW-1:0] r;
    r = sat_x(XW'(a) - XW'(b));
    return r;
  endfunction

  function automatic logic [DW-1:0] mag(input logic signed [DW-1:0] x);
    logic [DW-1:0] r;
    r = x[DW-1] ? DW'(-x) : DW'(x);
    return r;
  endfunction

  function automatic logic signed [31:0] sat_o(input logic signed [DW-1:0] v);
    logic signed [XW-1:0] x;
    logic signed [31:0]   r;
    x = XW'(v);
    if (x > OMAX_X) r = OMAX_X[31:0];
    else if (x < OMIN_X) r = OMIN_X[31:0];
    else r = x[31:0];
    return r;
  endfunction

  // state and configuration
  logic signed [DW-1:0] angle_q, angle_d, bias_q, bias_d;
  logic signed [DW-1:0] p00_q, p00_d, p01_q, p01_d, p10_q, p10_d, p11_q, p11_d;
  logic [30:0]          qa_q, qa_d, qb_q, qb_d, rm_q, rm_d;
  logic                 done_q, done_d;
  logic                 mul_busy_q, mul_busy_d, mul_fin_q, mul_fin_d;
  logic [MCW-1:0]       mul_cnt_q, mul_cnt_d;
  abkf_pkg::abkf_op_e   pend_q, pend_d;
  logic                 div_wait_q, div_wait_d;

  // payload
  logic signed [DW-1:0] meas_q, meas_d, gyro_q, gyro_d;
  logic [15:0]          dt_q, dt_d;
  logic signed [DW-1:0] tmp_q, tmp_d, cbd_q, cbd_d, k0_q, k0_d, k1_q, k1_d;
  logic [DW-1:0]        mul_a_q, mul_a_d;
  logic [BW-1:0]        mul_b_q, mul_b_d;
  logic [PW-1:0]        mul_acc_q, mul_acc_d;
  logic                 mul_neg_q, mul_neg_d, mul_fx_q, mul_fx_d;
  logic signed [31:0]   oang_q, oang_d, obias_q, obias_d;

  logic                 div_start, div_done;
  logic signed [DW-1:0] div_q0, div_q1;
  logic signed [DW-1:0] mul_res;
  logic signed [DW-1:0] qa_s, qb_s, rm_s;
  logic [PW-1:0]        mul_sh, mul_lim, mul_cl;
  logic [DW+15:0]       mul_pp;

  assign qa_s = sat_x(XW'(qa_q));
  assign qb_s = sat_x(XW'(qb_q));
  assign rm_s = sat_x(XW'(rm_q));

  assign mul_pp  = (DW+16)'(mul_a_q) * (DW+16)'(mul_b_q[BW-1 -: 16]);
  assign mul_sh  = mul_fx_q ? (mul_acc_q >> FB) : (mul_acc_q >> 16);
  assign mul_lim = mul_neg_q ? LIM_N : LIM_P;
  assign mul_cl  = (mul_sh > mul_lim) ? mul_lim : mul_sh;
  assign mul_res = mul_neg_q ? -$signed(mul_cl[DW-1:0]) : $signed(mul_cl[DW-1:0]);

  abkf_div #(.DW(DW), .FB(FB)) u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(div_start),
    .num0_i (p00_q),
    .num1_i (p10_q),
    .den_i  (tmp_q),
    .done_o (div_done),
    .quo0_o (div_q0),
    .quo1_o (div_q1)
  );

  always_comb begin
    logic                 mstart;
    logic                 mfx;
    logic signed [DW-1:0] ma;
    logic signed [DW-1:0] mb;
    angle_d = angle_q; bias_d = bias_q;
    p00_d = p00_q; p01_d = p01_q; p10_d = p10_q; p11_d = p11_q;
    qa_d = qa_q; qb_d = qb_q; rm_d = rm_q;
    done_d = 1'b0;
    mul_busy_d = mul_busy_q; mul_fin_d = 1'b0; mul_cnt_d = mul_cnt_q;
    pend_d = pend_q; div_wait_d = div_wait_q;
    meas_d = meas_q; gyro_d = gyro_q; dt_d = dt_q;
    tmp_d = tmp_q; cbd_d = cbd_q; k0_d = k0_q; k1_d = k1_q;
    mul_a_d = mul_a_q; mul_b_d = mul_b_q; mul_acc_d = mul_acc_q;
    mul_neg_d = mul_neg_q; mul_fx_d = mul_fx_q;
    oang_d = oang_q; obias_d = obias_q;
    div_start = 1'b0;
    mstart = 1'b0; mfx = 1'b0; ma = tmp_q; mb = tmp_q;

    if (cfg_we_i) begin
      unique case (cfg_index_i)
        abkf_pkg::CFG_ANGLE_NOISE: qa_d = cfg_data_i[30:0];
        abkf_pkg::CFG_BIAS_NOISE:  qb_d = cfg_data_i[30:0];
        abkf_pkg::CFG_MEAS_NOISE:  rm_d = cfg_data_i[30:0];
        abkf_pkg::CFG_START_ANGLE: begin
          angle_d = sat_x(XW'($signed(cfg_data_i)));
          bias_d  = '0;
          p00_d   = ONE;
          p01_d   = '0;
          p10_d   = '0;
          p11_d   = ONE;
        end
        default: ;
      endcase
    end

    if (cmd_i.load) begin
      meas_d = sat_x(XW'(measured_angle_i));
      gyro_d = sat_x(XW'(gyro_rate_i));
      dt_d   = time_step_i;
    end

    if (cmd_i.capture) begin
      oang_d  = sat_o(angle_q);
      obias_d = sat_o(bias_q);
    end

    if (cmd_i.issue) begin
      unique case (cmd_i.op)
        abkf_pkg::OP_RATE:     begin tmp_d = sub_s(gyro_q, bias_q); done_d = 1'b1; end
        abkf_pkg::OP_T1:       begin tmp_d = sub_s(cbd_q, p01_q); done_d = 1'b1; end
        abkf_pkg::OP_T2:       begin tmp_d = sub_s(tmp_q, p10_q); done_d = 1'b1; end
        abkf_pkg::OP_T3:       begin tmp_d = add_s(tmp_q, qa_s); done_d = 1'b1; end
        abkf_pkg::OP_P01_PRED: begin p01_d = sub_s(p01_q, cbd_q); done_d = 1'b1; end
        abkf_pkg::OP_P10_PRED: begin p10_d = sub_s(p10_q, cbd_q); done_d = 1'b1; end
        abkf_pkg::OP_INNOV:    begin tmp_d = add_s(p00_q, rm_s); done_d = 1'b1; end
        abkf_pkg::OP_RESID:    begin tmp_d = sub_s(meas_q, angle_q); done_d = 1'b1; end
        abkf_pkg::OP_GAIN: begin
          if (tmp_q == '0) begin
            k0_d   = '0;
            k1_d   = '0;
            done_d = 1'b1;
          end else begin
            div_start  = 1'b1;
            div_wait_d = 1'b1;
          end
        end
        abkf_pkg::OP_ANG_PRED:  begin mstart = 1'b1; ma = tmp_q; end
        abkf_pkg::OP_CBD:       begin mstart = 1'b1; ma = p11_q; end
        abkf_pkg::OP_P00_PRED:  begin mstart = 1'b1; ma = tmp_q; end
        abkf_pkg::OP_P11_PRED:  begin mstart = 1'b1; ma = qb_s; end
        abkf_pkg::OP_ANG_CORR:  begin mstart = 1'b1; mfx = 1'b1; ma = k0_q; mb = tmp_q; end
        abkf_pkg::OP_BIAS_CORR: begin mstart = 1'b1; mfx = 1'b1; ma = k1_q; mb = tmp_q; end
        abkf_pkg::OP_P10_CORR:  begin mstart = 1'b1; mfx = 1'b1; ma = k1_q; mb = p00_q; end
        abkf_pkg::OP_P00_CORR:  begin mstart = 1'b1; mfx = 1'b1; ma = k0_q; mb = p00_q; end
        abkf_pkg::OP_P11_CORR:  begin mstart = 1'b1; mfx = 1'b1; ma = k1_q; mb = p01_q; end
        abkf_pkg::OP_P01_CORR:  begin mstart = 1'b1; mfx = 1'b1; ma = k0_q; mb = p01_q; end
        default: ;
      endcase
    end

    if (mstart) begin
      pend_d     = cmd_i.op;
      mul_fx_d   = mfx;
      mul_a_d    = mag(ma);
      mul_b_d    = mfx ? BW'(mag(mb)) : BW'(dt_q);
      mul_neg_d  = mfx ? (ma[DW-1] ^ mb[DW-1]) : ma[DW-1];
      mul_acc_d  = '0;
      mul_cnt_d  = '0;
      mul_busy_d = 1'b1;
    end else if (mul_busy_q) begin
      mul_acc_d = (mul_acc_q << 16) + PW'(mul_pp);
      mul_b_d   = mul_b_q << 16;
      if (mul_cnt_q == MCW'(NCH - 1)) begin
        mul_busy_d = 1'b0;
        mul_fin_d  = 1'b1;
      end else begin
        mul_cnt_d = mul_cnt_q + MCW'(1);
      end
    end

    if (mul_fin_q) begin
      done_d = 1'b1;
      case (pend_q)
        abkf_pkg::OP_ANG_PRED:  angle_d = add_s(angle_q, mul_res);
        abkf_pkg::OP_CBD:       cbd_d   = mul_res;
        abkf_pkg::OP_P00_PRED:  p00_d   = add_s(p00_q, mul_res);
        abkf_pkg::OP_P11_PRED:  p11_d   = add_s(p11_q, mul_res);
        abkf_pkg::OP_ANG_CORR:  angle_d = add_s(angle_q, mul_res);
        abkf_pkg::OP_BIAS_CORR: bias_d  = add_s(bias_q, mul_res);
        abkf_pkg::OP_P10_CORR:  p10_d   = sub_s(p10_q, mul_res);
        abkf_pkg::OP_P00_CORR:  p00_d   = sub_s(p00_q, mul_res);
        abkf_pkg::OP_P11_CORR:  p11_d   = sub_s(p11_q, mul_res);
        abkf_pkg::OP_P01_CORR:  p01_d   = sub_s(p01_q, mul_res);
        default: ;
      endcase
    end

    if (div_wait_q && div_done) begin
      k0_d       = div_q0;
      k1_d       = div_q1;
      div_wait_d = 1'b0;
      done_d     = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      angle_q    <= '0;
      bias_q     <= '0;
      p00_q      <= ONE;
      p01_q      <= '0;
      p10_q      <= '0;
      p11_q      <= ONE;
      qa_q       <= 31'd66;
      qb_q       <= 31'd197;
      rm_q       <= 31'd1966;
      done_q     <= 1'b0;
      mul_busy_q <= 1'b0;
      mul_fin_q  <= 1'b0;
      mul_cnt_q  <= '0;
      pend_q     <= abkf_pkg::OP_FIRST;
      div_wait_q <= 1'b0;
    end else begin
      angle_q    <= angle_d;
      bias_q     <= bias_d;
      p00_q      <= p00_d;
      p01_q      <= p01_d;
      p10_q      <= p10_d;
      p11_q      <= p11_d;
      qa_q       <= qa_d;
      qb_q       <= qb_d;
      rm_q       <= rm_d;
      done_q     <= done_d;
      mul_busy_q <= mul_busy_d;
      mul_fin_q  <= mul_fin_d;
      mul_cnt_q  <= mul_cnt_d;
      pend_q     <= pend_d;
      div_wait_q <= div_wait_d;
    end
  end

  always_ff @(posedge clk_i) begin
    meas_q    <= meas_d;
    gyro_q    <= gyro_d;
    dt_q      <= dt_d;
    tmp_q     <= tmp_d;
    cbd_q     <= cbd_d;
    k0_q      <= k0_d;
    k1_q      <= k1_d;
    mul_a_q   <= mul_a_d;
    mul_b_q   <= mul_b_d;
    mul_acc_q <= mul_acc_d;
    mul_neg_q <= mul_neg_d;
    mul_fx_q  <= mul_fx_d;
    oang_q    <= oang_d;
    obias_q   <= obias_d;
  end

  assign sts_o.done       = done_q;
  assign angle_estimate_o = oang_q;
  assign bias_estimate_o  = obias_q;

endmodule

FILE: design/abkf_ctrl.sv
// ----------------------------------------------------------------------------
// abkf_ctrl
// Sequencer: steps the datapath through one filter update per transaction.
// ----------------------------------------------------------------------------
module abkf_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output abkf_pkg::abkf_cmd_t cmd_o,
  input  abkf_pkg::abkf_sts_t sts_i
);

  localparam logic [1:0] ST_IDLE   = 2'd0;
  localparam logic [1:0] ST_ISSUE  = 2'd1;
  localparam logic [1:0] ST_WAIT   = 2'd2;
  localparam logic [1:0] ST_FINISH = 2'd3;

  logic [1:0]         state_q, state_d;
  abkf_pkg::abkf_op_e op_q, op_d;
  logic               out_valid_q, out_valid_d;

  always_comb begin
    state_d     = state_q;
    op_d        = op_q;
    out_valid_d = out_valid_q & out_stall_i;
    cmd_o       = '{load: 1'b0, issue: 1'b0, op: op_q, capture: 1'b0};
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          op_d       = abkf_pkg::OP_FIRST;
          state_d    = ST_ISSUE;
        end
      end
      ST_ISSUE: begin
        cmd_o.issue = 1'b1;
        state_d     = ST_WAIT;
      end
      ST_WAIT: begin
        if (sts_i.done) begin
          if (op_q == abkf_pkg::OP_LAST) begin
            state_d = ST_FINISH;
          end else begin
            op_d    = abkf_pkg::abkf_op_e'(5'(op_q) + 5'd1);
            state_d = ST_ISSUE;
          end
        end
      end
      ST_FINISH: begin
        if (!out_valid_q || !out_stall_i) begin
          cmd_o.capture = 1'b1;
          out_valid_d   = 1'b1;
          state_d       = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      op_q        <= abkf_pkg::OP_FIRST;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      op_q        <= op_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign in_stall_o  = (state_q != ST_IDLE);
  assign out_valid_o = out_valid_q;

endmodule

FILE: design/angle_bias_kalman_filter.sv
// Each update steps through its ops from input accept to output valid; the next
// sample is accepted only once it is finished. NCH = DATA_WIDTH/16 rounded up.
// The ops are 8 adds/subtracts, 10 multiplies over NCH 16-bit chunks (16 bits a
// cycle) and the divider; the divider is skipped on zero innovation variance.
// A result waits in an output register while the next update runs.
// Reset loads default noise values, zero angle and bias, identity covariance.
// ----------------------------------------------------------------------------
// angle_bias_kalman_filter
// Two-state angle/bias Kalman filter with a sequencer and shared datapath.
// ----------------------------------------------------------------------------
module angle_bias_kalman_filter #(
  parameter int unsigned FRAC_BITS  = 16,
  parameter int unsigned DATA_WIDTH = 32
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  output logic                           in_stall_o,
  input  logic signed [31:0]             measured_angle_i,
  input  logic signed [31:0]             gyro_rate_i,
  input  logic [15:0]                    time_step_i,
  output logic                           out_valid_o,
  input  logic                           out_stall_i,
  output logic signed [31:0]             angle_estimate_o,
  output logic signed [31:0]             bias_estimate_o,
  input  logic                           cfg_valid_i,
  output logic                           cfg_ready_o,
  input  logic [abkf_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  logic [31:0]                    cfg_data_i
);

  abkf_pkg::abkf_cmd_t cmd;
  abkf_pkg::abkf_sts_t sts;

  assign cfg_ready_o = 1'b1;

  abkf_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .cmd_o      (cmd),
    .sts_i      (sts)
  );

  abkf_dp #(.DW(DATA_WIDTH), .FB(FRAC_BITS)) u_dp (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (cmd),
    .sts_o           (sts),
    .cfg_we_i        (cfg_valid_i & cfg_ready_o),
    .cfg_index_i     (cfg_index_i),
    .cfg_data_i      (cfg_data_i),
    .measured_angle_i(measured_angle_i),
    .gyro_rate_i     (gyro_rate_i),
    .time_step_i     (time_step_i),
    .angle_estimate_o(angle_estimate_o),
    .bias_estimate_o (bias_estimate_o)
  );

endmodule

FILE: tb/sv/angle_bias_kalman_filter_test.sv
// ----------------------------------------------------------------------------
// angle_bias_kalman_filter_test
// Drives angle/gyro/step samples and register writes into the filter, predicts
// each angle and bias estimate with a fixed-point model of the filter and
// compares every output transaction in order, under random idle and stall.
// ----------------------------------------------------------------------------
module angle_bias_kalman_filter_test;

  localparam longint MAX_V = 64'sd2147483647;
  localparam longint MIN_V = -64'sd2147483648;
  localparam longint ONE_FX = 64'sd65536;
  localparam int DRAIN_CYCLES = 300;

  typedef struct {
    logic signed [31:0] angle;
    logic signed [31:0] bias;
  } estimate_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic in_stall_o;
  logic signed [31:0] measured_angle_i = '0;
  logic signed [31:0] gyro_rate_i = '0;
  logic [15:0] time_step_i = '0;
  logic out_valid_o;
  logic out_stall_i = 1'b0;
  logic signed [31:0] angle_estimate_o;
  logic signed [31:0] bias_estimate_o;
  logic cfg_valid_i = 1'b0;
  logic cfg_ready_o;
  logic [abkf_pkg::CFG_IDX_W-1:0] cfg_index_i = '0;
  logic [31:0] cfg_data_i = '0;

  angle_bias_kalman_filter u_top (.*);

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  // filter model state
  longint q_angle, q_bias, r_meas, start_ang;
  longint est_angle, est_bias, p00, p01, p10, p11;
  estimate_t estimates_q[$];
  int errors = 0;
  int idle_pct = 0;
  int stall_pct = 0;

  function automatic longint clamp(longint x);
    return x > MAX_V ? MAX_V : (x < MIN_V ? MIN_V : x);
  endfunction

  function automatic longint absv(longint x);
    return x < 0 ? -x : x;
  endfunction

  function automatic longint signed_mag(longint m, bit neg);
    return neg ? clamp(-m) : clamp(m);
  endfunction

  function automatic longint scale_dt(longint x, longint dt);
    return signed_mag((absv(x) * dt) >>> 16, x < 0);
  endfunction

  function automatic longint fx_mul(longint a, longint b);
    return signed_mag((absv(a) * absv(b)) >>> 16, (a < 0) != (b < 0));
  endfunction

  function automatic longint fx_div(longint a, longint b);
    return signed_mag((absv(a) <<< 16) / absv(b), (a < 0) != (b < 0));
  endfunction

  function automatic void reload_filter();
    est_angle = start_ang;
    est_bias = 0;
    p00 = ONE_FX;
    p01 = 0;
    p10 = 0;
    p11 = ONE_FX;
  endfunction

  function automatic void apply_register(logic [abkf_pkg::CFG_IDX_W-1:0] idx,
                                         logic [31:0] d);
    case (idx)
      abkf_pkg::CFG_ANGLE_NOISE: q_angle = longint'(d[30:0]);
      abkf_pkg::CFG_BIAS_NOISE:  q_bias = longint'(d[30:0]);
      abkf_pkg::CFG_MEAS_NOISE:  r_meas = longint'(d[30:0]);
      abkf_pkg::CFG_START_ANGLE: begin
        start_ang = longint'(signed'(d));
        reload_filter();
      end
      default: ;
    endcase
  endfunction

  function automatic estimate_t predict_estimate(logic signed [31:0] meas,
                                                 logic signed [31:0] gyro,
                                                 logic [15:0] dt);
    longint rate, t, s, k0, k1, y, c00, c01, d;
    estimate_t e;
    d = longint'(dt);
    k0 = 0;
    k1 = 0;
    rate = clamp(longint'(gyro) - est_bias);
    est_angle = clamp(est_angle + scale_dt(rate, d));
    t = clamp(clamp(clamp(scale_dt(p11, d) - p01) - p10) + q_angle);
    p00 = clamp(p00 + scale_dt(t, d));
    t = scale_dt(p11, d);
    p01 = clamp(p01 - t);
    p10 = clamp(p10 - t);
    p11 = clamp(p11 + scale_dt(q_bias, d));
    s = clamp(p00 + r_meas);
    if (s != 0) begin
      k0 = fx_div(p00, s);
      k1 = fx_div(p10, s);
    end
    y = clamp(longint'(meas) - est_angle);
    est_angle = clamp(est_angle + fx_mul(k0, y));
    est_bias = clamp(est_bias + fx_mul(k1, y));
    c00 = p00;
    c01 = p01;
    p00 = clamp(p00 - fx_mul(k0, c00));
    p01 = clamp(p01 - fx_mul(k0, c01));
    p10 = clamp(p10 - fx_mul(k1, c00));
    p11 = clamp(p11 - fx_mul(k1, c01));
    e.angle = est_angle[31:0];
    e.bias = est_bias[31:0];
    return e;
  endfunction

  task automatic send_sample(logic signed [31:0] meas, logic signed [31:0] gyro,
                             logic [15:0] dt);
    bit done;
    if (($urandom % 100) < idle_pct) begin
      in_valid_i <= 1'b0;
      do @(posedge clk_i); while (($urandom % 100) < idle_pct);
    end
    in_valid_i <= 1'b1;
    measured_angle_i <= meas;
    gyro_rate_i <= gyro;
    time_step_i <= dt;
    done = 0;
    while (!done) begin
      @(negedge clk_i);
      if (!in_stall_o) begin
        estimates_q.push_back(predict_estimate(meas, gyro, dt));
        done = 1;
      end
      @(posedge clk_i);
    end
  endtask

  task automatic write_register(logic [abkf_pkg::CFG_IDX_W-1:0] idx, logic [31:0] d);
    bit done;
    in_valid_i <= 1'b0;
    while (estimates_q.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= d;
    done = 0;
    while (!done) begin
      @(negedge clk_i);
      if (cfg_ready_o) begin
        apply_register(idx, d);
        done = 1;
      end
      @(posedge clk_i);
    end
    cfg_valid_i <= 1'b0;
  endtask

  always @(posedge clk_i) out_stall_i <= ($urandom % 100) < stall_pct;

  always @(negedge clk_i) begin
    estimate_t e;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (estimates_q.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected estimate angle=%h bias=%h",
                                   angle_estimate_o, bias_estimate_o);
      end else begin
        e = estimates_q.pop_front();
        if (e.angle !== angle_estimate_o || e.bias !== bias_estimate_o) begin
          errors++;
          if (errors <= 10)
            $display("estimate mismatch: angle exp %h got %h, bias exp %h got %h",
                     e.angle, angle_estimate_o, e.bias, bias_estimate_o);
        end
      end
    end
  end

  function automatic logic [31:0] rand_noise();
    case ($urandom % 6)
      0: return 32'h0;
      1: return 32'h7fff_ffff | {1'($urandom % 2), 31'h0};
      2: return $urandom;
      default: return $urandom_range(0, 8000);
    endcase
  endfunction

  task automatic send_random_sample();
    if (($urandom % 5) == 0)
      send_sample($urandom, $urandom, 16'($urandom));
    else
      send_sample($signed($urandom_range(0, 2 * 90 * 65536)) - 90 * 65536,
                  $signed($urandom_range(0, 2 * 300 * 65536)) - 300 * 65536,
                  16'($urandom_range(0, 2000)));
  endtask

  task automatic test_reset_defaults();
    send_sample(32'sd0, 32'sd0, 16'd655);
    send_sample(32'sd10 <<< 16, 32'sd5 <<< 16, 16'd655);
    send_sample(32'h7fff_ffff, 32'h7fff_ffff, 16'hffff);
    send_sample(32'h8000_0000, 32'h8000_0000, 16'hffff);
    send_sample(32'h8000_0000, 32'h7fff_ffff, 16'd0);
    send_sample(32'h7fff_ffff, 32'h8000_0000, 16'd1);
  endtask

  task automatic test_zero_innovation();
    write_register(abkf_pkg::CFG_ANGLE_NOISE, 32'h0);
    write_register(abkf_pkg::CFG_BIAS_NOISE, 32'h0);
    write_register(abkf_pkg::CFG_MEAS_NOISE, 32'h0);
    write_register(abkf_pkg::CFG_START_ANGLE, 32'h0001_0000);
    send_sample(32'sd3 <<< 16, 32'sd1 <<< 16, 16'd0);
    send_sample(32'sd7 <<< 16, -32'sd2 <<< 16, 16'd0);
    send_sample(-32'sd7 <<< 16, 32'sd2 <<< 16, 16'd0);
  endtask

  task automatic test_saturation();
    write_register(abkf_pkg::CFG_ANGLE_NOISE, 32'hffff_ffff);
    write_register(abkf_pkg::CFG_BIAS_NOISE, 32'h7fff_ffff);
    write_register(abkf_pkg::CFG_MEAS_NOISE, 32'h7fff_ffff);
    write_register(abkf_pkg::CFG_START_ANGLE, 32'h7fff_ffff);
    send_sample(32'h8000_0000, 32'h8000_0000, 16'hffff);
    send_sample(32'h7fff_ffff, 32'h7fff_ffff, 16'hffff);
    write_register(abkf_pkg::CFG_START_ANGLE, 32'h8000_0000);
    send_sample(32'h7fff_ffff, 32'h8000_0000, 16'hffff);
    send_sample(32'h8000_0000, 32'h7fff_ffff, 16'h8000);
    send_sample(32'h0, 32'h0, 16'hffff);
  endtask

  task automatic test_random(int n_items, int idle, int stall);
    idle_pct = idle;
    stall_pct = stall;
    for (int i = 0; i < n_items; i++) begin
      if (i % 150 == 0) begin
        write_register(abkf_pkg::CFG_ANGLE_NOISE, rand_noise());
        write_register(abkf_pkg::CFG_BIAS_NOISE, rand_noise());
        write_register(abkf_pkg::CFG_MEAS_NOISE, rand_noise());
        write_register(abkf_pkg::CFG_START_ANGLE, ($urandom % 2) ? $urandom
                       : $signed($urandom_range(0, 60 * 65536)) - 30 * 65536);
      end
      send_random_sample();
    end
  endtask

  initial begin
    q_angle = 66;
    q_bias = 197;
    r_meas = 1966;
    start_ang = 0;
    reload_filter();
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_reset_defaults();
    test_zero_innovation();
    test_saturation();
    test_random(450, 0, 0);
    test_random(450, 73, 0);
    test_random(450, 0, 73);
    test_random(450, 8, 8);
    in_valid_i <= 1'b0;
    while (estimates_q.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (errors == 0) $display("angle_bias_kalman_filter_test passed");
    else $display("angle_bias_kalman_filter_test failed");
    $finish;
  end

  initial begin
    #40000000;
    $display("angle_bias_kalman_filter_test failed");
    $finish;
  end

endmodule
